// ===== hw/rtl/pts_pkg.sv =====
// Shared constants and codes of the priority task scheduler.
package pts_pkg;

    // Default size of the task table
    localparam int SLOT_COUNT_DEF = 16;

    // Stream widths: operation in tuser, priority in tdata, result in tdata
    localparam int USER_W = 2;
    localparam int PRIO_W = 8;
    localparam int IN_W   = 8;
    localparam int OUT_W  = 16;
    localparam int SLOT_W = 4;

    // Operation codes
    localparam logic [USER_W-1:0] OP_CREATE = 2'd0;
    localparam logic [USER_W-1:0] OP_SCHED  = 2'd1;
    localparam logic [USER_W-1:0] OP_YIELD  = 2'd2;

    // Slot status codes
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;

    // Result status codes
    localparam logic RES_OK   = 1'b0;
    localparam logic RES_FULL = 1'b1;

endpackage

// ===== hw/rtl/priority_task_scheduler.sv =====
// Task table with a highest-priority-ready scheduler driven by a one-slot-a-cycle scan.
// Every create, schedule or yield request scans all SLOT_COUNT slots, one slot per cycle
// through a single status read port and the priority memory; an unused operation code
// skips the scan and answers with the current slot. A new request is taken only once
// the result is loaded into the output register. Synchronous active-low reset frees
// every slot, clears the current slot, the idle slot record and the output valid flag.
module priority_task_scheduler #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [pts_pkg::IN_W-1:0]   s_axis_tdata,  // [7:0] priority_req
    input  logic [pts_pkg::USER_W-1:0] s_axis_tuser,  // [1:0] operation
    // result channel
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [pts_pkg::OUT_W-1:0]  m_axis_tdata   // [0] status, [4:1] slot_index,
                                                      // [8:5] previous_index, [9] switched
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRE    = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_SW1    = 3'd5;
    localparam logic [2:0] S_SW2    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // Map a slot index onto the 4-bit result field
    function automatic logic [pts_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [8:0] wide;
        wide = 9'(idx);
        return wide[pts_pkg::SLOT_W-1:0];
    endfunction

    // Slot status (reset to free) and slot priority memory
    logic [1:0]                r_status [SLOT_COUNT];
    logic [pts_pkg::PRIO_W-1:0] r_level [SLOT_COUNT];

    logic [2:0]                 r_state, n_state;
    logic [pts_pkg::USER_W-1:0] r_op, n_op;
    logic [pts_pkg::PRIO_W-1:0] r_prio, n_prio;
    logic [IDX_W-1:0]           r_current, n_current;
    logic [IDX_W-1:0]           r_prev, n_prev;
    logic [IDX_W-1:0]           r_next, n_next;
    logic                       r_idle_present, n_idle_present;
    logic [IDX_W-1:0]           r_idle_slot, n_idle_slot;
    logic [IDX_W-1:0]           r_scan, n_scan;

    // Scan results
    logic                       r_found_free, n_found_free;
    logic [IDX_W-1:0]           r_free, n_free;
    logic                       r_found_rdy, n_found_rdy;
    logic [IDX_W-1:0]           r_best_idx, n_best_idx;
    logic [pts_pkg::PRIO_W-1:0] r_best, n_best;

    // Registered read of the slot under scan
    logic                       r_q_vld;
    logic [1:0]                 r_q_st;
    logic [IDX_W-1:0]           r_q_idx;
    logic [pts_pkg::PRIO_W-1:0] r_q_lvl;

    // Result waiting for the output register
    logic                       r_res_status, n_res_status;
    logic [IDX_W-1:0]           r_res_slot, n_res_slot;
    logic                       r_res_sw, n_res_sw;

    logic                       r_out_valid, n_out_valid;
    logic [pts_pkg::OUT_W-1:0]  r_out_data, n_out_data;

    // Status port and memory write port
    logic [IDX_W-1:0]           rd_addr;
    logic [1:0]                 rd_st;
    logic                       st_we;
    logic [IDX_W-1:0]           st_waddr;
    logic [1:0]                 st_wdata;
    logic                       lvl_we;
    logic [pts_pkg::PRIO_W-1:0] lvl_wdata;

    // Next slot choice of the schedule step
    logic                       pick_have;
    logic [IDX_W-1:0]           pick;

    assign rd_st         = r_status[rd_addr];
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Sequencer and shared compare unit
    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_prio         = r_prio;
        n_current      = r_current;
        n_prev         = r_prev;
        n_next         = r_next;
        n_idle_present = r_idle_present;
        n_idle_slot    = r_idle_slot;
        n_scan         = r_scan;
        n_found_free   = r_found_free;
        n_free         = r_free;
        n_found_rdy    = r_found_rdy;
        n_best_idx     = r_best_idx;
        n_best         = r_best;
        n_res_status   = r_res_status;
        n_res_slot     = r_res_slot;
        n_res_sw       = r_res_sw;
        n_out_valid    = r_out_valid;
        n_out_data     = r_out_data;
        rd_addr        = r_scan;
        st_we          = 1'b0;
        st_waddr       = r_current;
        st_wdata       = pts_pkg::ST_FREE;
        lvl_we         = 1'b0;
        lvl_wdata      = r_prio;
        pick_have      = 1'b0;
        pick           = r_current;

        // drop the result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op   = s_axis_tuser;
                    n_prio = s_axis_tdata[pts_pkg::PRIO_W-1:0];
                    n_prev = r_current;
                    if (s_axis_tuser inside {pts_pkg::OP_CREATE, pts_pkg::OP_SCHED,
                                             pts_pkg::OP_YIELD}) begin
                        n_state = S_PRE;
                    end else begin
                        // unused code: answer with the current slot
                        n_res_status = pts_pkg::RES_OK;
                        n_res_slot   = r_current;
                        n_res_sw     = 1'b0;
                        n_state      = S_DONE;
                    end
                end
            end
            S_PRE: begin
                // yield hands the current slot back unless it is free
                rd_addr = r_current;
                if (r_op == pts_pkg::OP_YIELD && rd_st != pts_pkg::ST_FREE) begin
                    st_we    = 1'b1;
                    st_waddr = r_current;
                    st_wdata = pts_pkg::ST_READY;
                end
                n_scan       = '0;
                n_found_free = 1'b0;
                n_found_rdy  = 1'b0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                rd_addr = r_scan;
                n_scan  = r_scan + 1'b1;
                if (r_scan == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res_sw = 1'b0;
                if (r_op == pts_pkg::OP_CREATE) begin
                    if (r_found_free) begin
                        st_we        = 1'b1;
                        st_waddr     = r_free;
                        st_wdata     = pts_pkg::ST_READY;
                        lvl_we       = 1'b1;
                        lvl_wdata    = r_prio;
                        n_res_status = pts_pkg::RES_OK;
                        n_res_slot   = r_free;
                    end else begin
                        n_res_status = pts_pkg::RES_FULL;
                        n_res_slot   = '0;
                    end
                    n_state = S_DONE;
                end else begin
                    if (r_found_rdy) begin
                        pick_have = 1'b1;
                        pick      = r_best_idx;
                    end else if (r_idle_present) begin
                        pick_have = 1'b1;
                        pick      = r_idle_slot;
                    end else if (r_found_free) begin
                        // claim the idle slot at the lowest priority
                        st_we          = 1'b1;
                        st_waddr       = r_free;
                        st_wdata       = pts_pkg::ST_READY;
                        lvl_we         = 1'b1;
                        lvl_wdata      = '0;
                        n_idle_present = 1'b1;
                        n_idle_slot    = r_free;
                        pick_have      = 1'b1;
                        pick           = r_free;
                    end
                    if (!pick_have) begin
                        n_res_status = pts_pkg::RES_FULL;
                        n_res_slot   = r_current;
                        n_state      = S_DONE;
                    end else if (pick == r_current) begin
                        n_res_status = pts_pkg::RES_OK;
                        n_res_slot   = r_current;
                        n_state      = S_DONE;
                    end else begin
                        n_next  = pick;
                        n_state = S_SW1;
                    end
                end
            end
            S_SW1: begin
                // old slot back to ready unless free
                rd_addr = r_current;
                if (rd_st != pts_pkg::ST_FREE) begin
                    st_we    = 1'b1;
                    st_waddr = r_current;
                    st_wdata = pts_pkg::ST_READY;
                end
                n_state = S_SW2;
            end
            S_SW2: begin
                st_we        = 1'b1;
                st_waddr     = r_next;
                st_wdata     = pts_pkg::ST_RUNNING;
                n_current    = r_next;
                n_res_status = pts_pkg::RES_OK;
                n_res_slot   = r_next;
                n_res_sw     = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'b0, r_res_sw, to_slot(r_prev), to_slot(r_res_slot),
                                   r_res_status};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // compare the slot read last cycle
        if (r_q_vld) begin
            if (r_q_st == pts_pkg::ST_FREE && !r_found_free) begin
                n_found_free = 1'b1;
                n_free       = r_q_idx;
            end
            if (r_q_st == pts_pkg::ST_READY && (!r_found_rdy || r_q_lvl > r_best)) begin
                n_found_rdy = 1'b1;
                n_best_idx  = r_q_idx;
                n_best      = r_q_lvl;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_current      <= '0;
            r_idle_present <= 1'b0;
            r_idle_slot    <= '0;
            r_out_valid    <= 1'b0;
            r_q_vld        <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_current      <= n_current;
            r_idle_present <= n_idle_present;
            r_idle_slot    <= n_idle_slot;
            r_out_valid    <= n_out_valid;
            r_q_vld        <= (r_state == S_SCAN);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_prio       <= n_prio;
        r_prev       <= n_prev;
        r_next       <= n_next;
        r_scan       <= n_scan;
        r_found_free <= n_found_free;
        r_free       <= n_free;
        r_found_rdy  <= n_found_rdy;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_sw     <= n_res_sw;
        r_out_data   <= n_out_data;
        r_q_st       <= rd_st;
        r_q_idx      <= r_scan;
    end

    // Slot status: all free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= pts_pkg::ST_FREE;
            end
        end else if (st_we) begin
            r_status[st_waddr] <= st_wdata;
        end
    end

    // Priority memory: one write port, registered read at the scan address
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_level[st_waddr] <= lvl_wdata;
        end
        r_q_lvl <= r_level[r_scan];
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the priority task scheduler: directed table, random requests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = pts_pkg::SLOT_COUNT_DEF;
    localparam logic [pts_pkg::USER_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1250;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int HOLD_OFF_AFTER = 400;

    // Result fields from the lowest bit up: status, slot, previous slot, switched
    typedef struct packed {
        logic                       switched;
        logic [pts_pkg::SLOT_W-1:0] prev;
        logic [pts_pkg::SLOT_W-1:0] slot;
        logic                       status;
    } sched_result_t;

    typedef struct packed {
        logic [pts_pkg::USER_W-1:0] op;
        logic [pts_pkg::PRIO_W-1:0] prio;
        logic                       typed;
        sched_result_t              want;
    } stim_row_t;

    localparam sched_result_t UNTYPED = '0;
    localparam int NUM_DIRECTED = 25;

    // Directed requests; result fields in order switched, prev, slot, status
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // yield on a free slot, idle made
        '{pts_pkg::OP_YIELD,  8'h00, 1'b1, '{1'b0, 4'd0, 4'd0, pts_pkg::RES_OK}},
        // unused code does nothing
        '{OP_UNUSED,          8'hFF, 1'b1, '{1'b0, 4'd0, 4'd0, pts_pkg::RES_OK}},
        '{pts_pkg::OP_CREATE, 8'hFF, 1'b1, '{1'b0, 4'd0, 4'd1, pts_pkg::RES_OK}},
        '{pts_pkg::OP_CREATE, 8'h00, 1'b1, '{1'b0, 4'd0, 4'd2, pts_pkg::RES_OK}},
        '{pts_pkg::OP_SCHED,  8'h00, 1'b0, UNTYPED},
        '{pts_pkg::OP_SCHED,  8'hA5, 1'b0, UNTYPED},   // running task loses its place
        '{pts_pkg::OP_YIELD,  8'h5A, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h80, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h01, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hFE, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hFF, 1'b0, UNTYPED},   // tie on the top priority
        '{pts_pkg::OP_SCHED,  8'h00, 1'b0, UNTYPED},
        '{pts_pkg::OP_YIELD,  8'h00, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h7F, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h55, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hAA, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h0F, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hF0, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h33, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hCC, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'h01, 1'b0, UNTYPED},
        '{pts_pkg::OP_CREATE, 8'hFE, 1'b0, UNTYPED},   // last free slot
        '{pts_pkg::OP_CREATE, 8'hFF, 1'b0, UNTYPED},   // table full
        '{pts_pkg::OP_SCHED,  8'h00, 1'b0, UNTYPED},
        '{pts_pkg::OP_YIELD,  8'h00, 1'b0, UNTYPED}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [pts_pkg::IN_W-1:0]   s_axis_tdata;   // [7:0] priority_req
    logic [pts_pkg::USER_W-1:0] s_axis_tuser;   // [1:0] operation
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [pts_pkg::OUT_W-1:0]  m_axis_tdata;   // [0] status, [4:1] slot_index,
                                                // [8:5] previous_index, [9] switched

    priority_task_scheduler #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the task table
    logic [1:0]                 task_state [SLOTS];
    logic [pts_pkg::PRIO_W-1:0] task_prio  [SLOTS];
    logic [pts_pkg::SLOT_W-1:0] cur_slot;
    logic                       idle_made;
    logic [pts_pkg::SLOT_W-1:0] idle_at;

    sched_result_t pending_results [$];
    int mismatch_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int n_create = 0, n_sched = 0, n_yield = 0, n_unused = 0;
    int n_full = 0, n_switch = 0;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Take the lowest free slot at the given priority; -1 when the table is full
    function automatic int claim_free_slot(input logic [pts_pkg::PRIO_W-1:0] prio);
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (task_state[i] == pts_pkg::ST_FREE) begin
                task_state[i] = pts_pkg::ST_READY;
                task_prio[i]  = prio;
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one request to the table mirror and return the result it should give
    function automatic sched_result_t predict_scheduler(
        input logic [pts_pkg::USER_W-1:0] op,
        input logic [pts_pkg::PRIO_W-1:0] prio);
        sched_result_t r;
        logic [pts_pkg::SLOT_W-1:0] nxt;
        logic [pts_pkg::PRIO_W-1:0] best;
        logic found;
        int free_at;
        int i;
        r.status   = pts_pkg::RES_OK;
        r.prev     = cur_slot;
        r.slot     = cur_slot;
        r.switched = 1'b0;
        if (op == pts_pkg::OP_CREATE) begin
            free_at = claim_free_slot(prio);
            if (free_at < 0) begin
                r.status = pts_pkg::RES_FULL;
                r.slot   = '0;
            end else begin
                r.slot = pts_pkg::SLOT_W'(free_at);
            end
        end else if (op == pts_pkg::OP_SCHED || op == pts_pkg::OP_YIELD) begin
            if (op == pts_pkg::OP_YIELD && task_state[cur_slot] != pts_pkg::ST_FREE)
                task_state[cur_slot] = pts_pkg::ST_READY;
            // highest priority ready slot, lowest index on a tie
            found = 1'b0;
            best  = '0;
            nxt   = '0;
            for (i = 0; i < SLOTS; i++) begin
                if (task_state[i] == pts_pkg::ST_READY &&
                    (!found || task_prio[i] > best)) begin
                    best  = task_prio[i];
                    nxt   = pts_pkg::SLOT_W'(i);
                    found = 1'b1;
                end
            end
            // fall back on the idle slot, making it on first use
            if (!found && !idle_made) begin
                free_at = claim_free_slot('0);
                if (free_at < 0) begin
                    r.status = pts_pkg::RES_FULL;
                end else begin
                    idle_made = 1'b1;
                    idle_at   = pts_pkg::SLOT_W'(free_at);
                end
            end
            if (r.status == pts_pkg::RES_OK) begin
                if (!found)
                    nxt = idle_at;
                if (nxt != cur_slot) begin
                    if (task_state[cur_slot] != pts_pkg::ST_FREE)
                        task_state[cur_slot] = pts_pkg::ST_READY;
                    task_state[nxt] = pts_pkg::ST_RUNNING;
                    r.switched = 1'b1;
                end
                cur_slot = nxt;
            end
            r.slot = cur_slot;
        end
        return r;
    endfunction

    // Offer one request after a random gap and record its expected result on acceptance
    logic sender_steady = 1'b0;

    task automatic send_request(input logic [pts_pkg::USER_W-1:0] op,
                                input logic [pts_pkg::PRIO_W-1:0] prio,
                                input logic typed, input sched_result_t want);
        int gap;
        sched_result_t predicted;
        if ($urandom_range(0, 59) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= prio;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = predict_scheduler(op, prio);
        pending_results.push_back(typed ? want : predicted);
        case (op)
            pts_pkg::OP_CREATE: n_create++;
            pts_pkg::OP_SCHED:  n_sched++;
            pts_pkg::OP_YIELD:  n_yield++;
            default:            n_unused++;
        endcase
    endtask

    // Take results with random stalls, one long hold-off, and compare each field
    task automatic collect_results();
        int gap;
        logic steady;
        sched_result_t got;
        sched_result_t want;
        steady = 1'b0;
        forever begin
            if ($urandom_range(0, 59) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 12);
            if (results_seen == HOLD_OFF_AFTER)
                gap = HOLD_OFF_CYCLES;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            results_seen++;
            got = m_axis_tdata[9:0];
            if (got.switched)
                n_switch++;
            if (got.status == pts_pkg::RES_FULL)
                n_full++;
            if (m_axis_tdata[pts_pkg::OUT_W-1:10] != '0)
                report_mismatch($sformatf("padding bits set in result %h", m_axis_tdata));
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %h with no request outstanding",
                                          m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, got.status, want.status));
                if (got.slot != want.slot)
                    report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                              results_seen, got.slot, want.slot));
                if (got.prev != want.prev)
                    report_mismatch($sformatf("result %0d previous slot %0d, want %0d",
                                              results_seen, got.prev, want.prev));
                if (got.switched != want.switched)
                    report_mismatch($sformatf("result %0d switched %0d, want %0d",
                                              results_seen, got.switched, want.switched));
            end
        end
    endtask

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("priority_task_scheduler regression: fail");
            $finish;
        end
    end

    initial begin
        int i;
        int pick;
        logic [pts_pkg::USER_W-1:0] op;
        // hold every input known through reset
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            task_state[i] = pts_pkg::ST_FREE;
            task_prio[i]  = '0;
        end
        cur_slot  = '0;
        idle_made = 1'b0;
        idle_at   = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        fork
            collect_results();
        join_none

        // walk the directed table
        for (i = 0; i < NUM_DIRECTED; i++)
            send_request(DIRECTED[i].op, DIRECTED[i].prio, DIRECTED[i].typed,
                         DIRECTED[i].want);

        // random mix, weighted towards schedule and yield
        for (i = 0; i < RANDOM_REQUESTS; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                op = pts_pkg::OP_SCHED;
            else if (pick < 7)
                op = pts_pkg::OP_YIELD;
            else if (pick < 9)
                op = pts_pkg::OP_CREATE;
            else
                op = OP_UNUSED;
            send_request(op, pts_pkg::PRIO_W'($urandom), 1'b0, UNTYPED);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for a late stray result
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * SLOTS + 8) @(posedge i_clk);

        $display("covered %0d creates, %0d schedules, %0d yields, %0d unused-code requests",
                 n_create, n_sched, n_yield, n_unused);
        $display("saw %0d task switches and %0d table-full answers in %0d results",
                 n_switch, n_full, results_seen);
        if (mismatch_count == 0) begin
            $display("priority_task_scheduler regression: pass");
        end else begin
            $display("priority_task_scheduler regression: fail");
        end
        $finish;
    end

endmodule
